/* hw/rtl/stc_pkg.sv */
// Shared types, codes and helpers for the square tone channel with sweep.
// Used by stc_channel and the top level; no dependencies.
`timescale 1ns / 1ps

package stc_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_FRAME = 3'd1,
        FUNC_WRITE = 3'd2,
        FUNC_READ  = 3'd3,
        FUNC_POWER = 3'd4
    } func_t;

    localparam logic [2:0] REG_SWEEP   = 3'd0;
    localparam logic [2:0] REG_DUTYLEN = 3'd1;
    localparam logic [2:0] REG_ENV     = 3'd2;
    localparam logic [2:0] REG_FREQ_LO = 3'd3;
    localparam logic [2:0] REG_FREQ_HI = 3'd4;

    localparam logic CFG_SWEEP_FITTED = 1'b0;
    localparam logic CFG_MODEL_DMG    = 1'b1;

    localparam logic [10:0] FREQ_MAX     = 11'h7FF;
    localparam logic [6:0]  LEN_FULL     = 7'h40;
    localparam logic [6:0]  LEN_RETRIG   = 7'h3F;
    localparam logic [13:0] PERIOD_RESET = 14'd8192;

    // bit i is duty step i
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b1110_0001,
        8'b0111_1110
    };

    typedef struct packed {
        func_t      func;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic signed [3:0] sample;
        logic              channel_on;
    } result_t;

    typedef struct packed {
        logic sweep_fitted;
        logic model_is_dmg;
    } cfg_t;

    typedef struct packed {
        logic        powered;
        logic        chan_enabled;
        logic [2:0]  frame_step;
        logic [1:0]  duty_sel;
        logic [2:0]  duty_position;
        logic [10:0] tone_freq;
        logic [13:0] period_count;
        logic [3:0]  env_start_vol;
        logic        env_up;
        logic [2:0]  env_period;
        logic [7:0]  env_count;
        logic [3:0]  env_volume;
        logic        env_running;
        logic [6:0]  len_count;
        logic        len_enabled;
        logic [2:0]  sweep_period;
        logic [2:0]  sweep_shift;
        logic        sweep_down;
        logic        sweep_down_used;
        logic        sweep_active;
        logic [7:0]  sweep_count;
        logic [10:0] shadow_freq;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        powered: 1'b0, chan_enabled: 1'b0, frame_step: 3'd0, duty_sel: 2'd0,
        duty_position: 3'd0, tone_freq: 11'd0, period_count: PERIOD_RESET,
        env_start_vol: 4'd0, env_up: 1'b0, env_period: 3'd0, env_count: 8'd0,
        env_volume: 4'd0, env_running: 1'b0, len_count: 7'd0, len_enabled: 1'b0,
        sweep_period: 3'd0, sweep_shift: 3'd0, sweep_down: 1'b0,
        sweep_down_used: 1'b0, sweep_active: 1'b0, sweep_count: 8'd0,
        shadow_freq: 11'd0
    };

    // swept frequency; bit 11 set means overflow past 0x7FF
    function automatic logic [11:0] next_freq(input logic [10:0] shadow,
                                              input logic [2:0]  shift,
                                              input logic        down);
        logic [11:0] delta;
        delta = {1'b0, shadow} >> shift;
        return down ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
    endfunction

    // timer reload: (2048 - freq) * 4
    function automatic logic [13:0] period_reload(input logic [10:0] freq);
        logic [11:0] diff;
        diff = 12'h800 - {1'b0, freq};
        return {diff, 2'b00};
    endfunction

endpackage

/* hw/rtl/stc_channel.sv */
// Channel state and the single-pass update for one word.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_channel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  stc_pkg::item_t  item,
    input  stc_pkg::cfg_t   cfg,
    output stc_pkg::result_t result
);
    import stc_pkg::*;

    chan_state_t state_reg;
    chan_state_t state_next;
    logic [11:0] nf;
    logic [11:0] nf2;
    logic [7:0]  rd;
    logic [3:0]  level;
    logic [7:0]  v;

    assign v = item.write_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CHAN_RESET;
        else if (step_en)
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rd         = 8'hFF;
        nf         = '0;
        nf2        = '0;
        level      = '0;
        case (item.func)
            FUNC_TICK:
            begin
                if (state_reg.powered)
                begin
                    state_next.period_count = state_reg.period_count - 14'd1;
                    if (state_next.period_count == '0)
                    begin
                        state_next.period_count  = period_reload(state_reg.tone_freq);
                        state_next.duty_position = state_reg.duty_position + 3'd1;
                    end
                end
            end
            FUNC_FRAME:
            begin
                if (state_reg.powered)
                begin
                    // length on even steps
                    if (!state_reg.frame_step[0] && state_reg.len_enabled
                        && state_reg.len_count != '0)
                    begin
                        state_next.len_count = state_reg.len_count - 7'd1;
                        if (state_next.len_count == '0)
                            state_next.chan_enabled = 1'b0;
                    end
                    // envelope on step 7
                    if (state_reg.frame_step == 3'd7)
                    begin
                        state_next.env_count = state_reg.env_count - 8'd1;
                        if (state_next.env_count == '0)
                        begin
                            if (state_reg.env_period == '0)
                                state_next.env_count = 8'd8;
                            else
                            begin
                                state_next.env_count = {5'd0, state_reg.env_period};
                                if (state_reg.env_running)
                                begin
                                    if (state_reg.env_up)
                                    begin
                                        if (state_reg.env_volume != 4'd15)
                                            state_next.env_volume = state_reg.env_volume + 4'd1;
                                        else
                                            state_next.env_running = 1'b0;
                                    end
                                    else
                                    begin
                                        if (state_reg.env_volume != 4'd0)
                                            state_next.env_volume = state_reg.env_volume - 4'd1;
                                        else
                                            state_next.env_running = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    // sweep on steps 2 and 6
                    if (cfg.sweep_fitted && state_reg.frame_step[1:0] == 2'b10
                        && state_reg.sweep_active)
                    begin
                        state_next.sweep_count = state_reg.sweep_count - 8'd1;
                        if (state_next.sweep_count == '0)
                        begin
                            if (state_reg.sweep_period == '0)
                                state_next.sweep_count = 8'd8;
                            else
                            begin
                                state_next.sweep_count = {5'd0, state_reg.sweep_period};
                                nf = next_freq(state_reg.shadow_freq, state_reg.sweep_shift,
                                               state_reg.sweep_down);
                                state_next.sweep_down_used = state_reg.sweep_down;
                                if (nf[11])
                                    state_next.chan_enabled = 1'b0;
                                else if (state_reg.sweep_shift != '0)
                                begin
                                    state_next.shadow_freq = nf[10:0];
                                    state_next.tone_freq   = nf[10:0];
                                    nf2 = next_freq(nf[10:0], state_reg.sweep_shift,
                                                    state_reg.sweep_down);
                                    if (nf2[11])
                                        state_next.chan_enabled = 1'b0;
                                end
                            end
                        end
                    end
                    state_next.frame_step = state_reg.frame_step + 3'd1;
                end
            end
            FUNC_WRITE:
            begin
                if (item.reg_index == REG_DUTYLEN)
                begin
                    if (state_reg.powered)
                        state_next.duty_sel = v[7:6];
                    if (state_reg.powered || cfg.model_is_dmg)
                        state_next.len_count = LEN_FULL - {1'b0, v[5:0]};
                end
                else if (state_reg.powered)
                begin
                    case (item.reg_index)
                        REG_SWEEP:
                        begin
                            if (cfg.sweep_fitted)
                            begin
                                state_next.sweep_period = v[6:4];
                                state_next.sweep_shift  = v[2:0];
                                // leaving negate mode after a negate calc kills the channel
                                if (state_reg.sweep_down && !v[3] && state_reg.sweep_down_used)
                                    state_next.chan_enabled = 1'b0;
                                state_next.sweep_down = v[3];
                            end
                        end
                        REG_ENV:
                        begin
                            state_next.env_start_vol = v[7:4];
                            state_next.env_up        = v[3];
                            state_next.env_period    = v[2:0];
                            if (state_reg.chan_enabled)
                                state_next.chan_enabled = (v[7:4] != '0) || v[3];
                        end
                        REG_FREQ_LO:
                        begin
                            state_next.tone_freq = {state_reg.tone_freq[10:8], v};
                        end
                        REG_FREQ_HI:
                        begin
                            state_next.tone_freq = {v[2:0], state_reg.tone_freq[7:0]};
                            if (v[7])
                            begin
                                state_next.chan_enabled = (state_reg.env_start_vol != '0)
                                                          || state_reg.env_up;
                                if (state_reg.len_count == '0)
                                begin
                                    state_next.len_count   = LEN_FULL;
                                    state_next.len_enabled = 1'b0;
                                end
                                state_next.period_count = period_reload(state_next.tone_freq);
                                state_next.env_count = (state_reg.env_period != '0)
                                    ? {5'd0, state_reg.env_period} : 8'd8;
                                state_next.env_volume  = state_reg.env_start_vol;
                                state_next.env_running = 1'b1;
                                if (cfg.sweep_fitted)
                                begin
                                    state_next.shadow_freq = state_next.tone_freq;
                                    state_next.sweep_count = (state_reg.sweep_period != '0)
                                        ? {5'd0, state_reg.sweep_period} : 8'd8;
                                    state_next.sweep_active = (state_reg.sweep_period != '0)
                                                              || (state_reg.sweep_shift != '0);
                                    state_next.sweep_down_used = 1'b0;
                                    if (state_reg.sweep_shift != '0)
                                    begin
                                        nf = next_freq(state_next.tone_freq,
                                                       state_reg.sweep_shift,
                                                       state_reg.sweep_down);
                                        if (nf[11])
                                            state_next.chan_enabled = 1'b0;
                                        state_next.sweep_down_used = state_reg.sweep_down;
                                    end
                                end
                            end
                            // extra length clock when enabling in the first half of a step
                            if (state_reg.frame_step[0] && !state_next.len_enabled && v[6]
                                && state_next.len_count != '0)
                            begin
                                state_next.len_count = state_next.len_count - 7'd1;
                                if (state_next.len_count == '0)
                                begin
                                    if (!v[7])
                                        state_next.chan_enabled = 1'b0;
                                    else
                                        state_next.len_count = LEN_RETRIG;
                                end
                            end
                            state_next.len_enabled = v[6];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FUNC_READ:
            begin
                case (item.reg_index)
                    REG_SWEEP:
                        rd = cfg.sweep_fitted ? {1'b1, state_reg.sweep_period,
                                                 state_reg.sweep_down, state_reg.sweep_shift}
                                              : 8'hFF;
                    REG_DUTYLEN:
                        rd = {state_reg.duty_sel, 6'h3F};
                    REG_ENV:
                        rd = {state_reg.env_start_vol, state_reg.env_up, state_reg.env_period};
                    REG_FREQ_HI:
                        rd = {1'b1, state_reg.len_enabled, 6'h3F};
                    default:
                        rd = 8'hFF;
                endcase
            end
            FUNC_POWER:
            begin
                if (!state_reg.powered && v[7])
                    state_next.powered = 1'b1;
                else if (state_reg.powered && !v[7])
                begin
                    state_next = CHAN_RESET;
                    if (!cfg.sweep_fitted)
                    begin
                        state_next.sweep_period    = state_reg.sweep_period;
                        state_next.sweep_shift     = state_reg.sweep_shift;
                        state_next.sweep_down      = state_reg.sweep_down;
                        state_next.sweep_down_used = state_reg.sweep_down_used;
                        state_next.sweep_active    = state_reg.sweep_active;
                        state_next.sweep_count     = state_reg.sweep_count;
                        state_next.shadow_freq     = state_reg.shadow_freq;
                    end
                    if (cfg.model_is_dmg)
                        state_next.len_count = state_reg.len_count;
                end
            end
            default:
            begin
            end
        endcase

        if (DUTY_WAVE[state_next.duty_sel][state_next.duty_position])
            level = state_next.env_volume;
        result.read_data  = rd;
        result.sample     = state_next.chan_enabled ? signed'(4'd7 - level) : 4'sd0;
        result.channel_on = state_next.chan_enabled;
    end

endmodule

/* hw/rtl/square_tone_channel_with_sweep_top.sv */
// Top level: stream ports, input word register, result register, config port.
// Depends on stc_pkg and stc_channel.
// Each accepted word is held in the input word register; its result is registered in the result register.
// Throughput: one word per cycle; the input register drains whenever the
// result register is empty or being taken.
// Reset: async active low; channel powered off, sweep fitted, original length rules.
`timescale 1ns / 1ps

module square_tone_channel_with_sweep_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_index, [10:3] write_data
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [11:8] sample, [12] channel_on
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import stc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    cfg_t    cfg_reg;
    result_t result;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{sweep_fitted: 1'b1, model_is_dmg: 1'b1};
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SWEEP_FITTED: cfg_reg.sweep_fitted <= cfg_data;
                    CFG_MODEL_DMG:    cfg_reg.model_is_dmg <= cfg_data;
                    default:          cfg_reg              <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func       <= func_t'(s_tuser);
            in_item_reg.reg_index  <= s_tdata[2:0];
            in_item_reg.write_data <= s_tdata[10:3];
        end
        if (advance)
            out_data_reg <= result;
    end

    stc_channel u_channel (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.channel_on, out_data_reg.sample,
                       out_data_reg.read_data};

endmodule

/* hw/rtl/stc_checker.sv */
// Port-level checks for the square tone channel top, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module stc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_we,
    input logic        cfg_index,
    input logic        cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // input never blocks while the output side can move
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

    // a disabled channel outputs a zero sample
    a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[12] |-> m_tdata[11:8] == 4'd0)
        else $error("nonzero sample with channel off");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:13] == 3'd0)
        else $error("result padding not zero");

endmodule

bind square_tone_channel_with_sweep_top stc_checker u_stc_checker (.*);

/* verif/stc_channel_checker.sv */
// Output checker for the square tone channel: predicts every result word from
// the accepted input words and config writes and compares it field by field.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_channel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_index, [10:3] write_data
    input  logic [2:0]  s_tuser,   // [2:0] func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] read_data, [11:8] sample, [12] channel_on
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output int          mismatches,
    output int          outputs_owed
);
    import stc_pkg::*;

    chan_state_t ch;
    logic        sweep_en;
    logic        dmg_mode;
    result_t     channel_outputs_due [$];
    result_t     due;
    result_t     got;
    result_t     predicted;

    // duty table, bit i is step i
    function automatic logic pulse_high(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] shape;
        case (sel)
            2'd0:    shape = 8'h80;
            2'd1:    shape = 8'h81;
            2'd2:    shape = 8'hE1;
            default: shape = 8'h7E;
        endcase
        return shape[pos];
    endfunction

    // result of one sweep calculation; bit 11 set means past 0x7FF
    function automatic logic [11:0] sweep_target(input chan_state_t s);
        logic [11:0] delta;
        delta = {1'b0, s.shadow_freq} >> s.sweep_shift;
        if (s.sweep_down)
        begin
            return {1'b0, s.shadow_freq} - delta;
        end
        return {1'b0, s.shadow_freq} + delta;
    endfunction

    function automatic logic [7:0] reg_readback(input logic [2:0] idx);
        case (idx)
            REG_SWEEP:
            begin
                if (!sweep_en)
                begin
                    return 8'hFF;
                end
                return {1'b1, ch.sweep_period, ch.sweep_down, ch.sweep_shift};
            end
            REG_DUTYLEN: return {ch.duty_sel, 6'h3F};
            REG_ENV:     return {ch.env_start_vol, ch.env_up, ch.env_period};
            REG_FREQ_HI: return {1'b1, ch.len_enabled, 6'h3F};
            default:     return 8'hFF;
        endcase
    endfunction

    task automatic length_clock();
        if (ch.len_enabled && ch.len_count != 7'd0)
        begin
            ch.len_count = ch.len_count - 7'd1;
            if (ch.len_count == 7'd0)
            begin
                ch.chan_enabled = 1'b0;
            end
        end
    endtask

    task automatic envelope_clock();
        ch.env_count = ch.env_count - 8'd1;
        if (ch.env_count == 8'd0)
        begin
            if (ch.env_period == 3'd0)
            begin
                ch.env_count = 8'd8;
            end
            else
            begin
                ch.env_count = {5'd0, ch.env_period};
                if (ch.env_running)
                begin
                    if (ch.env_up)
                    begin
                        if (ch.env_volume != 4'hF)
                        begin
                            ch.env_volume = ch.env_volume + 4'd1;
                        end
                        else
                        begin
                            ch.env_running = 1'b0;
                        end
                    end
                    else if (ch.env_volume != 4'd0)
                    begin
                        ch.env_volume = ch.env_volume - 4'd1;
                    end
                    else
                    begin
                        ch.env_running = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic sweep_clock();
        logic [11:0] nf;
        if (ch.sweep_active)
        begin
            ch.sweep_count = ch.sweep_count - 8'd1;
            if (ch.sweep_count == 8'd0)
            begin
                if (ch.sweep_period == 3'd0)
                begin
                    ch.sweep_count = 8'd8;
                end
                else
                begin
                    ch.sweep_count = {5'd0, ch.sweep_period};
                    nf = sweep_target(ch);
                    ch.sweep_down_used = ch.sweep_down;
                    if (nf[11])
                    begin
                        ch.chan_enabled = 1'b0;
                    end
                    else if (ch.sweep_shift != 3'd0)
                    begin
                        ch.shadow_freq = nf[10:0];
                        ch.tone_freq = nf[10:0];
                        // second calculation only checks overflow
                        if (sweep_target(ch) > {1'b0, FREQ_MAX})
                        begin
                            ch.chan_enabled = 1'b0;
                        end
                    end
                end
            end
        end
    endtask

    task automatic trigger_channel();
        ch.chan_enabled = (ch.env_start_vol != 4'd0) || ch.env_up;
        if (ch.len_count == 7'd0)
        begin
            ch.len_count = LEN_FULL;
            ch.len_enabled = 1'b0;
        end
        ch.period_count = (14'h0800 - {3'd0, ch.tone_freq}) << 2;
        ch.env_count = (ch.env_period != 3'd0) ? {5'd0, ch.env_period} : 8'd8;
        ch.env_volume = ch.env_start_vol;
        ch.env_running = 1'b1;
        if (sweep_en)
        begin
            ch.shadow_freq = ch.tone_freq;
            ch.sweep_count = (ch.sweep_period != 3'd0) ? {5'd0, ch.sweep_period} : 8'd8;
            ch.sweep_active = (ch.sweep_period != 3'd0) || (ch.sweep_shift != 3'd0);
            ch.sweep_down_used = 1'b0;
            if (ch.sweep_shift != 3'd0)
            begin
                if (sweep_target(ch) > {1'b0, FREQ_MAX})
                begin
                    ch.chan_enabled = 1'b0;
                end
                ch.sweep_down_used = ch.sweep_down;
            end
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
        if (idx == REG_DUTYLEN)
        begin
            if (ch.powered)
            begin
                ch.duty_sel = v[7:6];
            end
            // original model keeps length writes alive while powered off
            if (ch.powered || dmg_mode)
            begin
                ch.len_count = LEN_FULL - {1'b0, v[5:0]};
            end
        end
        else if (ch.powered)
        begin
            case (idx)
                REG_SWEEP:
                begin
                    if (sweep_en)
                    begin
                        ch.sweep_period = v[6:4];
                        ch.sweep_shift = v[2:0];
                        // leaving negate mode after a negated calculation kills the channel
                        if (ch.sweep_down && !v[3] && ch.sweep_down_used)
                        begin
                            ch.chan_enabled = 1'b0;
                        end
                        ch.sweep_down = v[3];
                    end
                end
                REG_ENV:
                begin
                    ch.env_start_vol = v[7:4];
                    ch.env_up = v[3];
                    ch.env_period = v[2:0];
                    if (ch.chan_enabled)
                    begin
                        ch.chan_enabled = (v[7:4] != 4'd0) || v[3];
                    end
                end
                REG_FREQ_LO:
                begin
                    ch.tone_freq[7:0] = v;
                end
                REG_FREQ_HI:
                begin
                    ch.tone_freq[10:8] = v[2:0];
                    if (v[7])
                    begin
                        trigger_channel();
                    end
                    // enabling length in the first half of a length period clocks it once
                    if (ch.frame_step[0] && !ch.len_enabled && v[6] && ch.len_count != 7'd0)
                    begin
                        ch.len_count = ch.len_count - 7'd1;
                        if (ch.len_count == 7'd0)
                        begin
                            if (!v[7])
                            begin
                                ch.chan_enabled = 1'b0;
                            end
                            else
                            begin
                                ch.len_count = LEN_RETRIG;
                            end
                        end
                    end
                    ch.len_enabled = v[6];
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic power_down();
        ch.chan_enabled = 1'b0;
        if (sweep_en)
        begin
            ch.sweep_period = 3'd0;
            ch.sweep_shift = 3'd0;
            ch.sweep_down = 1'b0;
            ch.sweep_down_used = 1'b0;
            ch.sweep_active = 1'b0;
            ch.sweep_count = 8'd0;
            ch.shadow_freq = 11'd0;
        end
        ch.env_start_vol = 4'd0;
        ch.env_up = 1'b0;
        ch.env_period = 3'd0;
        ch.env_count = 8'd0;
        ch.env_volume = 4'd0;
        ch.env_running = 1'b0;
        ch.len_enabled = 1'b0;
        if (!dmg_mode)
        begin
            ch.len_count = 7'd0;
        end
        ch.duty_sel = 2'd0;
        ch.duty_position = 3'd0;
        ch.tone_freq = 11'd0;
        ch.period_count = PERIOD_RESET;
        ch.powered = 1'b0;
        ch.frame_step = 3'd0;
    endtask

    task automatic step_pulse_channel(input logic [2:0] code, input logic [2:0] idx,
                                      input logic [7:0] v, output result_t r);
        logic [7:0] rd;
        logic [3:0] level;
        rd = 8'hFF;
        case (code)
            FUNC_TICK:
            begin
                if (ch.powered)
                begin
                    ch.period_count = ch.period_count - 14'd1;
                    if (ch.period_count == 14'd0)
                    begin
                        ch.period_count = (14'h0800 - {3'd0, ch.tone_freq}) << 2;
                        ch.duty_position = ch.duty_position + 3'd1;
                    end
                end
            end
            FUNC_FRAME:
            begin
                if (ch.powered)
                begin
                    if (!ch.frame_step[0])
                    begin
                        length_clock();
                    end
                    if (ch.frame_step == 3'd7)
                    begin
                        envelope_clock();
                    end
                    if (sweep_en && ch.frame_step[1:0] == 2'd2)
                    begin
                        sweep_clock();
                    end
                    ch.frame_step = ch.frame_step + 3'd1;
                end
            end
            FUNC_WRITE:
            begin
                reg_write(idx, v);
            end
            FUNC_READ:
            begin
                rd = reg_readback(idx);
            end
            FUNC_POWER:
            begin
                if (!ch.powered && v[7])
                begin
                    ch.powered = 1'b1;
                end
                else if (ch.powered && !v[7])
                begin
                    power_down();
                end
            end
            default:
            begin
            end
        endcase
        level = pulse_high(ch.duty_sel, ch.duty_position) ? ch.env_volume : 4'd0;
        r.read_data = rd;
        r.sample = ch.chan_enabled ? 4'd7 - level : 4'd0;
        r.channel_on = ch.chan_enabled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch = '0;
            ch.period_count = PERIOD_RESET;
            sweep_en = 1'b1;
            dmg_mode = 1'b1;
            channel_outputs_due.delete();
            mismatches = 0;
            outputs_owed = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SWEEP_FITTED)
                begin
                    sweep_en = cfg_data;
                end
                else
                begin
                    dmg_mode = cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got.read_data = m_tdata[7:0];
                got.sample = m_tdata[11:8];
                got.channel_on = m_tdata[12];
                if (channel_outputs_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected word rd=%02h sample=%0d on=%0b", $time,
                                 got.read_data, got.sample, got.channel_on);
                    end
                    mismatches = mismatches + 1;
                end
                else
                begin
                    due = channel_outputs_due.pop_front();
                    if (got.read_data !== due.read_data || got.sample !== due.sample
                        || got.channel_on !== due.channel_on)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: exp rd=%02h sample=%0d on=%0b, got rd=%02h sample=%0d on=%0b",
                                     $time, due.read_data, due.sample, due.channel_on,
                                     got.read_data, got.sample, got.channel_on);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_pulse_channel(s_tuser, s_tdata[2:0], s_tdata[10:3], predicted);
                channel_outputs_due.push_back(predicted);
            end
            outputs_owed = channel_outputs_due.size();
        end
    end

endmodule

/* verif/square_tone_channel_with_sweep_top_tb.sv */
// Testbench top for the square tone channel: clock, reset, config writes and
// directed plus random input words; verdict from stc_channel_checker.
// Depends on stc_pkg, square_tone_channel_with_sweep_top and stc_channel_checker.
`timescale 1ns / 1ps

module square_tone_channel_with_sweep_top_tb;
    import stc_pkg::*;

    localparam int RUN_LIMIT     = 200000;
    localparam int SEGMENT_WORDS = 275;

    // codes the block must treat as no-ops
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_SPARE     = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [2:0] reg_index, [10:3] write_data
    logic [2:0]  s_tuser;   // [2:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] read_data, [11:8] sample, [12] channel_on
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;

    int mismatches;
    int outputs_owed;
    int cycles = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    square_tone_channel_with_sweep_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stc_channel_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outputs_owed (outputs_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("square_tone_channel_with_sweep_top_tb NOT OK");
            $finish;
        end
    end

    // called and returns at a falling edge; tvalid stays high on return
    task automatic put_word(input logic [2:0] code, input logic [2:0] idx,
                            input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= code;
        s_tdata <= {5'b00000, data, idx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (code <= FUNC_POWER)
        begin
            words_sent = words_sent + 1;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (outputs_owed != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic load_settings(input logic sweep_on, input logic dmg_on);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SWEEP_FITTED;
        cfg_data <= sweep_on;
        @(negedge clk);
        cfg_index <= CFG_MODEL_DMG;
        cfg_data <= dmg_on;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_words();
        put_word(FUNC_READ, REG_SWEEP, 8'h00);
        put_word(FUNC_READ, REG_SPARE, 8'h00);
        put_word(FUNC_WRITE, REG_DUTYLEN, 8'hFF);      // length write while off
        put_word(FUNC_TICK, REG_SPARE, 8'hFF);
        put_word(FUNC_FRAME, REG_SWEEP, 8'h00);
        put_word(FUNC_SPARE_LO, REG_SWEEP, 8'h00);
        put_word(FUNC_SPARE_HI, REG_SPARE, 8'hFF);
        put_word(FUNC_POWER, REG_SWEEP, 8'h7F);
        put_word(FUNC_POWER, REG_SWEEP, 8'h80);
        put_word(FUNC_WRITE, REG_SWEEP, 8'h11);
        put_word(FUNC_WRITE, REG_ENV, 8'hF0);
        put_word(FUNC_WRITE, REG_DUTYLEN, 8'hC0);
        put_word(FUNC_WRITE, REG_FREQ_LO, 8'hFF);
        put_word(FUNC_WRITE, REG_FREQ_HI, 8'hC7);      // trigger overflows at once
        put_word(FUNC_WRITE, REG_FREQ_LO, 8'h00);
        put_word(FUNC_WRITE, REG_FREQ_HI, 8'h84);
        repeat (3)
        begin
            put_word(FUNC_FRAME, REG_SWEEP, 8'h00);    // step 2 sweeps past max
        end
        put_word(FUNC_WRITE, REG_ENV, 8'h08);
        put_word(FUNC_WRITE, REG_SWEEP, 8'h0F);
        put_word(FUNC_WRITE, REG_FREQ_HI, 8'h87);
        put_word(FUNC_WRITE, REG_FREQ_HI, 8'h47);      // extra length clock, odd step
        put_word(FUNC_WRITE, REG_SWEEP, 8'h00);        // negate cleared after use
        put_word(FUNC_READ, REG_FREQ_HI, 8'h00);
        put_word(FUNC_POWER, REG_SWEEP, 8'h00);
        put_word(FUNC_READ, REG_ENV, 8'h00);
    endtask

    // well-formed setup and trigger, then timer, sequencer, read and write words
    task automatic tone_burst();
        logic [7:0] b;
        int pick;
        put_word(FUNC_POWER, 3'($urandom_range(0, 7)), 8'(8'h80 | $urandom_range(0, 127)));
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1)
        begin
            b[3] = 1'b1;
        end
        put_word(FUNC_WRITE, REG_SWEEP, b);
        b = 8'($urandom_range(0, 255));
        if (b[7:4] == 4'd0 && $urandom_range(0, 4) != 0)
        begin
            b[7:4] = 4'($urandom_range(1, 15));
        end
        put_word(FUNC_WRITE, REG_ENV, b);
        put_word(FUNC_WRITE, REG_DUTYLEN, 8'($urandom_range(0, 255)));
        b = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(240, 255))
                                       : 8'($urandom_range(0, 255));
        put_word(FUNC_WRITE, REG_FREQ_LO, b);
        b = 8'($urandom_range(0, 255));
        b[7] = 1'b1;
        if ($urandom_range(0, 3) != 0)
        begin
            b[2:0] = 3'd7;
        end
        put_word(FUNC_WRITE, REG_FREQ_HI, b);
        repeat ($urandom_range(8, 40))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                put_word(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
            begin
                put_word(FUNC_FRAME, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
            begin
                put_word(FUNC_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 97)
            begin
                // length enable toggle without trigger
                b = 8'($urandom_range(0, 127));
                b[2:0] = 3'd7;
                put_word(FUNC_WRITE, REG_FREQ_HI, b);
            end
            else
            begin
                put_word(FUNC_WRITE, REG_ENV, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic sweep_negate_run();
        logic [7:0] b;
        put_word(FUNC_POWER, 3'($urandom_range(0, 7)), 8'(8'h80 | $urandom_range(0, 127)));
        put_word(FUNC_WRITE, REG_ENV, 8'(8'hF0 | $urandom_range(0, 15)));
        b = 8'($urandom_range(0, 255));
        b[6:4] = 3'($urandom_range(1, 2));
        b[3] = 1'b1;
        b[2:0] = 3'($urandom_range(1, 7));
        put_word(FUNC_WRITE, REG_SWEEP, b);
        put_word(FUNC_WRITE, REG_FREQ_LO, 8'($urandom_range(0, 255)));
        b = 8'($urandom_range(0, 255));
        b[7:6] = 2'b10;
        put_word(FUNC_WRITE, REG_FREQ_HI, b);
        repeat ($urandom_range(2, 9))
        begin
            put_word(FUNC_FRAME, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
        b = 8'($urandom_range(0, 255));
        b[3] = 1'b0;
        put_word(FUNC_WRITE, REG_SWEEP, b);
        put_word(FUNC_READ, REG_SWEEP, 8'($urandom_range(0, 255)));
        put_word(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic power_cycle();
        int pick;
        put_word(FUNC_POWER, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 127)));
        repeat ($urandom_range(1, 3))
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: put_word(FUNC_WRITE, REG_DUTYLEN, 8'($urandom_range(0, 255)));
                1: put_word(FUNC_WRITE, REG_ENV, 8'($urandom_range(0, 255)));
                2: put_word(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                3: put_word(FUNC_FRAME, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                default: put_word(FUNC_READ, 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)));
            endcase
        end
        put_word(FUNC_POWER, 3'($urandom_range(0, 7)), 8'(8'h80 | $urandom_range(0, 127)));
    endtask

    task automatic read_all();
        for (int i = 0; i < 8; i++)
        begin
            put_word(FUNC_READ, 3'(i), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic noise_words();
        repeat ($urandom_range(1, 4))
        begin
            put_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_segment(input int goal);
        int stop_at;
        int pick;
        stop_at = words_sent + goal;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                tone_burst();
            end
            else if (pick < 60)
            begin
                sweep_negate_run();
            end
            else if (pick < 70)
            begin
                power_cycle();
            end
            else if (pick < 80)
            begin
                read_all();
            end
            else
            begin
                noise_words();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_settings(1'b1, 1'b1);
        send_idle_pct = 31;
        recv_idle_pct = 78;
        directed_words();
        random_segment(SEGMENT_WORDS);

        drain();
        load_settings(1'b0, 1'b0);
        send_idle_pct = 78;
        recv_idle_pct = 31;
        random_segment(SEGMENT_WORDS);

        drain();
        load_settings(1'b1, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_segment(SEGMENT_WORDS);

        drain();
        load_settings(1'b0, 1'b1);
        random_segment(SEGMENT_WORDS);

        drain();
        // catch stray words after the last expected one
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outputs_owed == 0)
        begin
            $display("square_tone_channel_with_sweep_top_tb OK");
        end
        else
        begin
            $display("square_tone_channel_with_sweep_top_tb NOT OK");
        end
        $finish;
    end

endmodule

/* square_tone_channel_with_sweep_top.f */
hw/rtl/stc_pkg.sv
hw/rtl/stc_channel.sv
hw/rtl/square_tone_channel_with_sweep_top.sv
hw/rtl/stc_checker.sv
verif/stc_channel_checker.sv
verif/square_tone_channel_with_sweep_top_tb.sv
